FILE: src/nfp_pkg.sv
`timescale 1ns / 1ps

package nfp_pkg;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_NUMBER_BASE         = 2'd0;
  localparam logic [1:0] REG_TERMINATOR_COUNT    = 2'd1;
  localparam logic [1:0] REG_TERMINATOR_CHARS    = 2'd2;
  localparam logic [1:0] REG_TERMINATOR_REQUIRED = 2'd3;

  // Result status codes.
  localparam logic [1:0] STATUS_OK      = 2'd0;
  localparam logic [1:0] STATUS_NO_TERM = 2'd1;
  localparam logic [1:0] STATUS_OVERFLOW = 2'd2;
  localparam logic [1:0] STATUS_INVALID = 2'd3;

  localparam int unsigned CNT_W           = 6;
  localparam int unsigned MAX_HEX_DIGITS  = 16;
  localparam int unsigned MAX_FIELD_CHARS = 32;
  localparam int unsigned MAX_TERMINATORS = 4;

  localparam logic [63:0] POS_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] NEG_LIMIT = 64'h8000_0000_0000_0000;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LF    = 8'h66;
  localparam logic [7:0] CHAR_UA    = 8'h41;
  localparam logic [7:0] CHAR_UF    = 8'h46;

  typedef struct packed {
    logic        number_base;
    logic [2:0]  term_count;
    logic [31:0] term_chars;
    logic        term_required;
  } cfg_t;

  typedef struct packed {
    logic       is_term;
    logic       is_nul;
    logic       is_minus;
    logic       is_dec;
    logic       is_hex;
    logic [3:0] digit;
  } char_class_t;

  typedef struct packed {
    logic [63:0]      value;
    logic [CNT_W-1:0] used;
    logic [1:0]       status;
  } result_t;

endpackage

FILE: src/nfp_cfg_regs.sv
`timescale 1ns / 1ps

module nfp_cfg_regs (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic [1:0]     cfg_idx_i,
  input  logic [31:0]    cfg_data_i,
  output nfp_pkg::cfg_t  cfg_o
);

  nfp_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        nfp_pkg::REG_NUMBER_BASE:         cfg_d.number_base   = cfg_data_i[0];
        nfp_pkg::REG_TERMINATOR_COUNT:    cfg_d.term_count    = cfg_data_i[2:0];
        nfp_pkg::REG_TERMINATOR_CHARS:    cfg_d.term_chars    = cfg_data_i;
        nfp_pkg::REG_TERMINATOR_REQUIRED: cfg_d.term_required = cfg_data_i[0];
        default:                          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

FILE: src/nfp_char_class.sv
`timescale 1ns / 1ps

module nfp_char_class (
  input  logic                 [7:0] char_i,
  input  nfp_pkg::cfg_t              cfg_i,
  output nfp_pkg::char_class_t       cls_o
);

  logic [2:0] active_terms;

  // Counts above four behave as four.
  assign active_terms = (cfg_i.term_count > 3'(nfp_pkg::MAX_TERMINATORS))
                        ? 3'(nfp_pkg::MAX_TERMINATORS) : cfg_i.term_count;

  always_comb begin
    cls_o          = '0;
    cls_o.is_nul   = (char_i == nfp_pkg::CHAR_NUL);
    cls_o.is_minus = (char_i == nfp_pkg::CHAR_MINUS);
    for (int k = 0; k < nfp_pkg::MAX_TERMINATORS; k++) begin
      if ((3'(k) < active_terms) && (cfg_i.term_chars[8*k +: 8] == char_i)) begin
        cls_o.is_term = 1'b1;
      end
    end
    if (char_i >= nfp_pkg::CHAR_ZERO && char_i <= nfp_pkg::CHAR_NINE) begin
      cls_o.is_dec = 1'b1;
      cls_o.is_hex = 1'b1;
      cls_o.digit  = 4'(char_i - nfp_pkg::CHAR_ZERO);
    end else if (char_i >= nfp_pkg::CHAR_LA && char_i <= nfp_pkg::CHAR_LF) begin
      cls_o.is_hex = 1'b1;
      cls_o.digit  = 4'(char_i - nfp_pkg::CHAR_LA + 8'd10);
    end else if (char_i >= nfp_pkg::CHAR_UA && char_i <= nfp_pkg::CHAR_UF) begin
      cls_o.is_hex = 1'b1;
      cls_o.digit  = 4'(char_i - nfp_pkg::CHAR_UA + 8'd10);
    end
  end

endmodule

FILE: src/nfp_field_engine.sv
`timescale 1ns / 1ps

module nfp_field_engine (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  nfp_pkg::char_class_t cls_i,
  input  logic                 last_i,
  input  nfp_pkg::cfg_t        cfg_i,
  output logic                 emit_o,
  output nfp_pkg::result_t     res_o
);

  localparam int unsigned CW = nfp_pkg::CNT_W;

  logic [63:0]   acc_q, acc_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic          neg_q, neg_d;
  logic          disc_q, disc_d;

  logic [63:0]   acc_n;
  logic [CW-1:0] cnt_n;
  logic          neg_n;
  logic [1:0]    err;
  logic [63:0]   lim;
  logic [67:0]   prod;

  function automatic nfp_pkg::result_t finish_field(
    input logic [63:0]   acc,
    input logic [CW-1:0] cnt,
    input logic          neg,
    input logic          by_term,
    input logic          by_nul,
    input nfp_pkg::cfg_t cfg
  );
    nfp_pkg::result_t r;
    logic [63:0]      flim;
    r.value  = acc;
    r.used   = cnt;
    r.status = nfp_pkg::STATUS_OK;
    flim     = neg ? nfp_pkg::NEG_LIMIT : nfp_pkg::POS_LIMIT;
    if (cfg.number_base) begin
      if (acc > flim) begin
        r.status = nfp_pkg::STATUS_OVERFLOW;
      end else if (neg) begin
        r.value = 64'd0 - acc;
      end
    end
    if (r.status == nfp_pkg::STATUS_OK && cfg.term_required) begin
      if ((cfg.term_count != 3'd0 && !by_term) || (cfg.term_count == 3'd0 && by_nul)) begin
        r.status = nfp_pkg::STATUS_NO_TERM;
      end
    end
    if (r.status != nfp_pkg::STATUS_OK) begin
      r.value = '0;
    end
    return r;
  endfunction

  // Magnitude times ten plus the digit, kept wide so the limit test is exact.
  assign lim  = neg_q ? nfp_pkg::NEG_LIMIT : nfp_pkg::POS_LIMIT;
  assign prod = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {64'b0, cls_i.digit};

  always_comb begin
    acc_n = acc_q;
    cnt_n = cnt_q;
    neg_n = neg_q;
    err   = nfp_pkg::STATUS_OK;
    if (cfg_i.number_base) begin
      if (cls_i.is_minus && cnt_q == '0 && !neg_q) begin
        neg_n = 1'b1;
        cnt_n = cnt_q + 1'b1;
      end else if (cls_i.is_dec) begin
        if (cnt_q >= CW'(nfp_pkg::MAX_FIELD_CHARS) || prod > {4'b0, lim}) begin
          err = nfp_pkg::STATUS_OVERFLOW;
        end else begin
          acc_n = prod[63:0];
          cnt_n = cnt_q + 1'b1;
        end
      end else begin
        err = nfp_pkg::STATUS_INVALID;
      end
    end else begin
      if (cnt_q >= CW'(nfp_pkg::MAX_HEX_DIGITS)) begin
        err = nfp_pkg::STATUS_OVERFLOW;
      end else if (!cls_i.is_hex) begin
        err = nfp_pkg::STATUS_INVALID;
      end else begin
        acc_n = {acc_q[59:0], cls_i.digit};
        cnt_n = cnt_q + 1'b1;
      end
    end
  end

  always_comb begin
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    neg_d  = neg_q;
    disc_d = disc_q;
    emit_o = 1'b0;
    res_o  = '0;
    if (disc_q) begin
      if (cls_i.is_term || cls_i.is_nul || last_i) begin
        disc_d = 1'b0;
        acc_d  = '0;
        cnt_d  = '0;
        neg_d  = 1'b0;
      end
    end else if (cls_i.is_term || cls_i.is_nul) begin
      emit_o = 1'b1;
      res_o  = finish_field(acc_q, cnt_q, neg_q, cls_i.is_term,
                            cls_i.is_nul && !cls_i.is_term, cfg_i);
      acc_d  = '0;
      cnt_d  = '0;
      neg_d  = 1'b0;
    end else if (err != nfp_pkg::STATUS_OK) begin
      // Error reports the count before the bad character, then drops to field end.
      emit_o       = 1'b1;
      res_o.value  = '0;
      res_o.used   = cnt_q;
      res_o.status = err;
      acc_d        = '0;
      cnt_d        = '0;
      neg_d        = 1'b0;
      disc_d       = !last_i;
    end else if (last_i) begin
      emit_o = 1'b1;
      res_o  = finish_field(acc_n, cnt_n, neg_n, 1'b0, 1'b0, cfg_i);
      acc_d  = '0;
      cnt_d  = '0;
      neg_d  = 1'b0;
    end else begin
      acc_d = acc_n;
      cnt_d = cnt_n;
      neg_d = neg_n;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      cnt_q  <= '0;
      neg_q  <= 1'b0;
      disc_q <= 1'b0;
    end else if (step_i) begin
      acc_q  <= acc_d;
      cnt_q  <= cnt_d;
      neg_q  <= neg_d;
      disc_q <= disc_d;
    end
  end

  a_disc_clear_field: assert property (@(posedge clk_i) disable iff (!rst_ni)
    disc_q |-> (acc_q == '0 && cnt_q == '0 && !neg_q))
    else $error("field state not cleared while dropping characters");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(nfp_pkg::MAX_FIELD_CHARS))
    else $error("character count beyond field limit");

  a_sign_counted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    neg_q |-> cnt_q != '0)
    else $error("sign held without being counted");

endmodule

FILE: src/number_field_parser_unit.sv
`timescale 1ns / 1ps

// Number field parser. Characters arrive one request at a time on the input
// channel and are built into a hexadecimal or signed decimal number; each
// field (ended by an active terminator, by NUL, by a character flagged as
// last, or cut short by its first error) yields exactly one request on the
// output channel carrying the value, the characters used and a status. The
// unit takes one character per clock cycle while its output is not backed
// up: a character is held in an input register, where it is classified and
// the field engine performs the single shift or times-ten add with its limit
// compare, and any result is loaded into the output register as the
// character moves on. The add and compare in the field engine sets the
// rate. When the output register holds a result that has not been taken,
// the input register holds its character and input ready falls once it is
// full. Configuration writes are registered and are meant to be made while
// no field is in progress.
module number_field_parser_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration write port
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [31:0]        cfg_data_i,
  // Character input
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [7:0]         text_char_i,
  input  logic               last_char_i,
  // Result output
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [63:0] number_value_o,
  output logic [5:0]         chars_used_o,
  output logic [1:0]         parse_status_o
);

  nfp_pkg::cfg_t        cfg;
  nfp_pkg::char_class_t cls;
  nfp_pkg::result_t     res;
  logic                 emit;

  // Input register stage.
  logic       in_valid_q, in_valid_d;
  logic [7:0] char_q, char_d;
  logic       last_q, last_d;
  logic       step;

  // Output register stage.
  logic             out_valid_q, out_valid_d;
  nfp_pkg::result_t out_q, out_d;

  // The held character moves on whenever the output register can take a result.
  assign step       = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !in_valid_q || step;

  nfp_cfg_regs u_cfg_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  nfp_char_class u_char_class (
    .char_i (char_q),
    .cfg_i  (cfg),
    .cls_o  (cls)
  );

  nfp_field_engine u_field_engine (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .cls_i  (cls),
    .last_i (last_q),
    .cfg_i  (cfg),
    .emit_o (emit),
    .res_o  (res)
  );

  always_comb begin
    in_valid_d = in_valid_q;
    char_d     = char_q;
    last_d     = last_q;
    if (in_valid_i && in_ready_o) begin
      in_valid_d = 1'b1;
      char_d     = text_char_i;
      last_d     = last_char_i;
    end else if (step) begin
      in_valid_d = 1'b0;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (step && emit) begin
      out_valid_d = 1'b1;
      out_d       = res;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    char_q <= char_d;
    last_q <= last_d;
    out_q  <= out_d;
  end

  assign out_valid_o    = out_valid_q;
  assign number_value_o = $signed(out_q.value);
  assign chars_used_o   = out_q.used;
  assign parse_status_o = out_q.status;

  a_err_value_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && parse_status_o != nfp_pkg::STATUS_OK) |-> number_value_o == '0)
    else $error("failed field carries a nonzero value");

  a_used_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> chars_used_o <= 6'(nfp_pkg::MAX_FIELD_CHARS))
    else $error("result reports too many characters");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> in_ready_o)
    else $error("input stalled with an empty input register");

endmodule

FILE: dv/number_field_parser_unit_test.sv
`timescale 1ns / 1ps

// Self-checking bench for the number field parser. Characters are fed as
// requests from a queue that the stimulus process fills, and every accepted
// character is run through a local model of the field engine, which queues
// the result that character should produce. The monitor takes each result
// request off the output channel and compares it, field by field, with the
// oldest queued result.
module number_field_parser_unit_test;
  import nfp_pkg::*;

  localparam int unsigned TOTAL_CHARS   = 1400;
  localparam int unsigned PHASE_CHARS   = 90;
  // A character passes the input register on its way to the output register,
  // so the settle wait lets one that produces no result clear.
  localparam int unsigned SETTLE_CYCLES = 6;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned MAX_PRINTED   = 50;

  typedef struct {
    logic [7:0] ch;
    logic       last;
  } text_req_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_idx = REG_NUMBER_BASE;
  logic [31:0] cfg_data = '0;
  logic        char_valid = 1'b0;
  logic [7:0]  text_char = CHAR_NUL;
  logic        last_char = 1'b0;
  logic        result_ready = 1'b0;

  logic               in_ready_o;
  logic               out_valid_o;
  logic signed [63:0] number_value_o;
  logic [5:0]         chars_used_o;
  logic [1:0]         parse_status_o;

  number_field_parser_unit uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (char_valid),
    .in_ready_o     (in_ready_o),
    .text_char_i    (text_char),
    .last_char_i    (last_char),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (result_ready),
    .number_value_o (number_value_o),
    .chars_used_o   (chars_used_o),
    .parse_status_o (parse_status_o)
  );

  // Characters waiting to be offered, and results still owed by the block.
  text_req_t pending_chars[$];
  result_t   expected_numbers[$];

  // Local copy of the configuration registers.
  logic        base_dec = 1'b0;
  logic [2:0]  term_cnt = '0;
  logic [31:0] term_bytes = '0;
  logic        term_needed = 1'b0;

  // Local copy of the field being built.
  logic [63:0]      fld_mag = '0;
  logic [CNT_W-1:0] fld_count = '0;
  logic             fld_neg = 1'b0;
  logic             skip_to_end = 1'b0;

  int unsigned mismatches = 0;
  int unsigned queued_chars = 0;
  int unsigned accepted_chars = 0;
  int unsigned settings_used = 0;
  int unsigned status_seen[4] = '{0, 0, 0, 0};
  int unsigned sender_idle_pct = 37;
  int unsigned receiver_idle_pct = 37;
  int unsigned hold_request = 0;
  int unsigned hold_served = 0;
  int unsigned hold_left = 0;
  logic        char_taken = 1'b0;
  text_req_t   next_req;
  result_t     got_number;
  result_t     want_number;

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or withholds a result.
  initial begin
    #4_000_000;
    $display("FAILURE");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= MAX_PRINTED) begin
      $display("%0t ns: mismatch: %s", $time, msg);
    end
  endtask

  // ---------------------------------------------------------------------
  // Field model
  // ---------------------------------------------------------------------

  // True when the character is one of the active terminators; a count above
  // four behaves as four.
  function automatic logic is_field_stop(input logic [7:0] c);
    int unsigned n;
    n = (term_cnt > MAX_TERMINATORS) ? MAX_TERMINATORS : term_cnt;
    for (int unsigned k = 0; k < n; k++) begin
      if (term_bytes[8*k +: 8] == c) begin
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  task automatic start_new_field();
    fld_mag = '0;
    fld_count = '0;
    fld_neg = 1'b0;
  endtask

  task automatic queue_number(input logic [63:0] value, input logic [1:0] status);
    result_t r;
    r = {(status == STATUS_OK) ? value : 64'd0, fld_count, status};
    expected_numbers.push_back(r);
  endtask

  // Closes the field normally. The sign is applied only in decimal mode, and
  // a decimal magnitude beyond the signed range reports overflow even if the
  // digits were gathered in hexadecimal mode.
  task automatic close_field(input logic by_term, input logic by_nul);
    logic [63:0] lim;
    logic [63:0] value;
    logic [1:0]  status;
    status = STATUS_OK;
    value = fld_mag;
    if (base_dec) begin
      lim = fld_neg ? NEG_LIMIT : POS_LIMIT;
      if (fld_mag > lim) begin
        status = STATUS_OVERFLOW;
      end else if (fld_neg) begin
        value = 64'd0 - fld_mag;
      end
    end
    // With terminators active the field must end on one; with none active,
    // ending on NUL counts as a missing terminator.
    if (status == STATUS_OK && term_needed) begin
      if ((term_cnt != 0 && !by_term) || (term_cnt == 0 && by_nul)) begin
        status = STATUS_NO_TERM;
      end
    end
    queue_number(value, status);
    start_new_field();
  endtask

  task automatic track_number_char(input logic [7:0] c, input logic last);
    logic        term;
    logic        nul;
    logic        failed;
    logic [1:0]  err_code;
    logic [63:0] d;
    logic [63:0] lim;
    int          hv;
    term = is_field_stop(c);
    nul = (c == CHAR_NUL);
    failed = 1'b0;
    err_code = STATUS_OK;
    accepted_chars++;

    // After an error everything up to and including the field end is dropped.
    if (skip_to_end) begin
      if (term || nul || last) begin
        skip_to_end = 1'b0;
        start_new_field();
      end
      return;
    end
    // A terminator wins over NUL when NUL is itself an active terminator.
    if (term || nul) begin
      close_field(term, nul && !term);
      return;
    end

    if (base_dec) begin
      if (c == CHAR_MINUS && fld_count == 0 && !fld_neg) begin
        fld_neg = 1'b1;
        fld_count++;
      end else if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        d = 64'(c - CHAR_ZERO);
        lim = fld_neg ? NEG_LIMIT : POS_LIMIT;
        if (fld_count >= MAX_FIELD_CHARS || fld_mag > (lim - d) / 64'd10) begin
          failed = 1'b1;
          err_code = STATUS_OVERFLOW;
        end else begin
          fld_mag = fld_mag * 64'd10 + d;
          fld_count++;
        end
      end else begin
        failed = 1'b1;
        err_code = STATUS_INVALID;
      end
    end else begin
      hv = -1;
      if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
        hv = c - CHAR_ZERO;
      end else if (c >= CHAR_LA && c <= CHAR_LF) begin
        hv = c - CHAR_LA + 10;
      end else if (c >= CHAR_UA && c <= CHAR_UF) begin
        hv = c - CHAR_UA + 10;
      end
      // The digit limit is checked before the character class.
      if (fld_count >= MAX_HEX_DIGITS) begin
        failed = 1'b1;
        err_code = STATUS_OVERFLOW;
      end else if (hv < 0) begin
        failed = 1'b1;
        err_code = STATUS_INVALID;
      end else begin
        fld_mag = {fld_mag[59:0], hv[3:0]};
        fld_count++;
      end
    end

    if (failed) begin
      // The count reported is the one before the offending character.
      queue_number(64'd0, err_code);
      start_new_field();
      skip_to_end = !last;
    end else if (last) begin
      close_field(1'b0, 1'b0);
    end
  endtask

  // ---------------------------------------------------------------------
  // Driver, receiver and monitor
  // ---------------------------------------------------------------------

  // Acceptance is seen at the rising edge; the model is stepped there, before
  // the block could possibly present the matching result.
  always @(posedge clk_i) begin
    char_taken <= char_valid && in_ready_o;
    if (rst_ni && char_valid && in_ready_o) begin
      track_number_char(text_char, last_char);
    end
  end

  // A request is only replaced once it has been taken, so valid and payload
  // stay steady while the block stalls.
  always @(negedge clk_i) begin
    if (!char_valid || char_taken) begin
      if (pending_chars.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
        next_req = pending_chars.pop_front();
        char_valid <= 1'b1;
        text_char <= next_req.ch;
        last_char <= next_req.last;
      end else begin
        char_valid <= 1'b0;
      end
    end
  end

  // The receiver stalls at random and, when asked, holds off for a long
  // stretch of its own counting so that the block backs up to its input.
  always @(negedge clk_i) begin
    if (hold_request != hold_served) begin
      hold_served = hold_request;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left != 0) begin
      hold_left--;
      result_ready <= 1'b0;
    end else begin
      result_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && result_ready) begin
      got_number = {number_value_o, chars_used_o, parse_status_o};
      if (expected_numbers.size() == 0) begin
        report_mismatch($sformatf("result value=%0d used=%0d status=%0d with none owed",
                                  $signed(got_number.value), got_number.used,
                                  got_number.status));
      end else begin
        want_number = expected_numbers.pop_front();
        status_seen[want_number.status]++;
        if (got_number.value !== want_number.value || got_number.used !== want_number.used ||
            got_number.status !== want_number.status) begin
          report_mismatch($sformatf("got value=%0d used=%0d status=%0d, want %0d/%0d/%0d",
                                    $signed(got_number.value), got_number.used,
                                    got_number.status, $signed(want_number.value),
                                    want_number.used, want_number.status));
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] data);
    @(negedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    case (idx)
      REG_NUMBER_BASE:         base_dec = data[0];
      REG_TERMINATOR_COUNT:    term_cnt = data[2:0];
      REG_TERMINATOR_CHARS:    term_bytes = data;
      REG_TERMINATOR_REQUIRED: term_needed = data[0];
      default: ;
    endcase
  endtask

  // Unused upper data bits carry noise; only the register's own bits count.
  task automatic configure(input logic base, input logic [2:0] cnt,
                           input logic [31:0] chars, input logic need);
    logic [31:0] junk;
    junk = $urandom;
    write_reg(REG_NUMBER_BASE, {junk[31:1], base});
    junk = $urandom;
    write_reg(REG_TERMINATOR_COUNT, {junk[31:3], cnt});
    write_reg(REG_TERMINATOR_CHARS, chars);
    junk = $urandom;
    write_reg(REG_TERMINATOR_REQUIRED, {junk[31:1], need});
    settings_used++;
  endtask

  // Waits until every character has gone in and every result has come out,
  // then lets any result-less character drain through the pipeline.
  task automatic wait_for_idle();
    while (pending_chars.size() != 0 || char_valid || expected_numbers.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic push_char(input logic [7:0] c, input logic last);
    text_req_t r;
    r.ch = c;
    r.last = last;
    pending_chars.push_back(r);
    queued_chars++;
  endtask

  task automatic queue_text(input string s, input logic last_at_end);
    for (int i = 0; i < s.len(); i++) begin
      push_char(s[i], last_at_end && (i == s.len() - 1));
    end
  endtask

  function automatic logic [7:0] pool_char();
    case ($urandom_range(7))
      0: return 8'h2C;  // comma
      1: return 8'h3B;  // semicolon
      2: return 8'h20;  // space
      3: return 8'h0A;  // line feed
      4: return 8'h3A;  // colon
      5: return 8'h2F;  // slash
      6: return CHAR_MINUS;
      default: return 8'h2E;  // full stop
    endcase
  endfunction

  // One random field: mostly well-formed numbers with random digits, some of
  // them pushed to the range limits, plus broken fields and plain noise.
  task automatic queue_random_field();
    logic [7:0]  body[$];
    logic [63:0] mag;
    string       digits;
    int unsigned roll;
    int unsigned n;
    int unsigned eff;
    int unsigned target;
    logic        neg;

    roll = $urandom_range(99);
    if (roll < 15) begin
      n = $urandom_range(1, 6);
      repeat (n) push_char(8'($urandom_range(255)), $urandom_range(99) < 20);
      return;
    end

    if (base_dec) begin
      neg = ($urandom_range(3) == 0);
      roll = $urandom_range(99);
      if (roll < 15) begin
        case ($urandom_range(5))
          0: mag = POS_LIMIT - 64'd1;
          1: mag = POS_LIMIT;
          2: mag = POS_LIMIT + 64'd1;
          3: mag = NEG_LIMIT;
          4: mag = NEG_LIMIT + 64'd1;
          default: mag = 64'd0;
        endcase
        digits = $sformatf("%0d", mag);
      end else if (roll < 18) begin
        digits = "99999999999999999999";
      end else begin
        digits = "";
      end
      if (digits.len() != 0) begin
        for (int i = 0; i < digits.len(); i++) body.push_back(digits[i]);
      end else begin
        n = ($urandom_range(9) < 7) ? $urandom_range(1, 6) : $urandom_range(7, 19);
        repeat (n) body.push_back(8'($urandom_range(CHAR_ZERO, CHAR_NINE)));
      end
      // Leading zeros around the field length limit.
      if ($urandom_range(9) == 0) begin
        target = $urandom_range(30, 34);
        while (body.size() + neg < target) body.push_front(CHAR_ZERO);
      end
      if (neg) begin
        body.push_front(CHAR_MINUS);
      end
    end else begin
      n = ($urandom_range(9) < 8) ? $urandom_range(0, 8) : $urandom_range(15, 18);
      repeat (n) begin
        roll = $urandom_range(21);
        if (roll < 10) begin
          body.push_back(8'(CHAR_ZERO + roll));
        end else if (roll < 16) begin
          body.push_back(8'(CHAR_LA + roll - 10));
        end else begin
          body.push_back(8'(CHAR_UA + roll - 16));
        end
      end
    end

    // Occasionally corrupt one character of an otherwise good field.
    if ($urandom_range(9) == 0 && body.size() != 0) begin
      body[$urandom_range(body.size() - 1)] = 8'($urandom_range(255));
    end

    eff = (term_cnt > MAX_TERMINATORS) ? MAX_TERMINATORS : term_cnt;
    roll = $urandom_range(99);
    if (roll >= 60 && roll < 92 && body.size() != 0) begin
      for (int i = 0; i < body.size(); i++) push_char(body[i], i == body.size() - 1);
    end else begin
      foreach (body[i]) push_char(body[i], 1'b0);
      if (roll < 40 && eff != 0) begin
        push_char(term_bytes[8*$urandom_range(eff - 1) +: 8], 1'b0);
      end else if (roll < 92) begin
        push_char(CHAR_NUL, 1'b0);
      end
      // Otherwise the field runs on into the next one.
    end
  endtask

  function automatic logic [31:0] pick_terminators(input int unsigned phase);
    case (phase % 8)
      3: return 32'h0000_0000;
      5: return 32'hFFFF_FFFF;
      6: return $urandom;
      default: return {pool_char(), pool_char(), pool_char(), pool_char()};
    endcase
  endfunction

  function automatic logic [2:0] pick_count(input int unsigned phase);
    case (phase % 8)
      0: return 3'd0;
      1: return 3'd4;
      2: return 3'd1;
      3: return 3'd7;
      4: return 3'd2;
      5: return 3'd3;
      6: return 3'd5;
      default: return 3'd6;
    endcase
  endfunction

  initial begin
    int unsigned phase;
    int unsigned phase_start;

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed fields under the reset settings: hexadecimal, no terminators.
    // Digit class edges, an invalid character flagged as last (nothing is
    // dropped), a NUL end, and an error followed by dropped characters.
    queue_text("09afAF", 1'b1);
    queue_text("g", 1'b1);
    queue_text("1", 1'b0);
    push_char(CHAR_NUL, 1'b0);
    queue_text("5z7", 1'b0);
    push_char(CHAR_NUL, 1'b0);
    queue_text("3", 1'b1);
    wait_for_idle();

    // Signed decimal with a comma terminator that is required: a negative
    // value, a missing terminator, a second minus, and an empty field.
    configure(1'b1, 3'd1, 32'h0000_002C, 1'b1);
    queue_text("-42,", 1'b0);
    queue_text("8", 1'b1);
    queue_text("--", 1'b1);
    queue_text(",", 1'b0);
    // A field started in decimal and finished in hexadecimal: the minus is
    // counted but no sign is applied.
    queue_text("-1", 1'b0);
    wait_for_idle();
    write_reg(REG_NUMBER_BASE, 32'd0);
    queue_text("F,", 1'b0);
    wait_for_idle();

    // Random phases, each under its own register setting.
    phase = 0;
    while (queued_chars < TOTAL_CHARS) begin
      // One phase runs flat out on both sides.
      sender_idle_pct = (phase == 2) ? 0 : 37;
      receiver_idle_pct = (phase == 2) ? 0 : 37;
      configure(phase[0], pick_count(phase), pick_terminators(phase), phase[1]);
      phase_start = queued_chars;
      while (queued_chars - phase_start < PHASE_CHARS) queue_random_field();
      if (phase == 5) begin
        hold_request++;
      end
      wait_for_idle();
      phase++;
    end

    $display("Covered %0d characters under %0d register settings in both number bases.",
             accepted_chars, settings_used);
    $display("Results checked: %0d ok, %0d no terminator, %0d overflow, %0d invalid.",
             status_seen[STATUS_OK], status_seen[STATUS_NO_TERM],
             status_seen[STATUS_OVERFLOW], status_seen[STATUS_INVALID]);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

FILE: number_field_parser_unit.f
src/nfp_pkg.sv
src/nfp_cfg_regs.sv
src/nfp_char_class.sv
src/nfp_field_engine.sv
src/number_field_parser_unit.sv
dv/number_field_parser_unit_test.sv
